// ----- design/linear_probe_hash_set_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the linear probe hash set
// Shared property forms, clocked on clk_i and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_SET_ASSERT_SVH
`define LINEAR_PROBE_HASH_SET_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define LPHS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define LPHS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/lphs_pkg.sv -----
// ---------------------------------------------------------------------------
// lphs_pkg
// Codes and fixed widths shared by the hash set modules.
// ---------------------------------------------------------------------------
package lphs_pkg;

  localparam int unsigned CFG_W      = 11;
  localparam int unsigned ACT_W      = 2;
  localparam int unsigned SLOT_W     = 10;
  localparam int unsigned IN_KEY_W   = 32;
  localparam int unsigned DIGIT_BITS = 4;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_SEARCH = 2'd2
  } act_e;

  typedef enum logic [1:0] {
    ST_EMPTY   = 2'd0,
    ST_ACTIVE  = 2'd1,
    ST_DELETED = 2'd2
  } slot_st_e;

endpackage

// ----- design/lphs_fifo.sv -----
// ---------------------------------------------------------------------------
// lphs_fifo
// Two-entry queue that decouples the hashing front from the probe engine.
// ---------------------------------------------------------------------------
module lphs_fifo #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_valid_i,
  output logic         wr_ready_o,
  input  logic [W-1:0] wr_data_i,
  output logic         rd_valid_o,
  input  logic         rd_ready_i,
  output logic [W-1:0] rd_data_o
);

  logic [W-1:0] mem_q [2];
  logic         wr_ptr_q, wr_ptr_d;
  logic         rd_ptr_q, rd_ptr_d;
  logic [1:0]   count_q, count_d;
  logic         do_wr, do_rd;

  assign wr_ready_o = (count_q != 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = do_wr ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_rd ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_wr && !do_rd) begin
      count_d = count_q + 2'd1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ----- design/lphs_front.sv -----
// ---------------------------------------------------------------------------
// lphs_front
// Accepts requests and computes the home slot, key modulo table size,
// four quotient bits per cycle.
// ---------------------------------------------------------------------------
module lphs_front #(
  parameter int unsigned KW = 32,
  parameter int unsigned AW = 10
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      s_valid_i,
  output logic                      s_ready_o,
  input  logic [lphs_pkg::ACT_W-1:0] action_i,
  input  logic [KW-1:0]             key_i,
  input  logic [lphs_pkg::CFG_W-1:0] m_i,
  output logic                      push_valid_o,
  input  logic                      push_ready_i,
  output logic [lphs_pkg::ACT_W-1:0] push_action_o,
  output logic [KW-1:0]             push_key_o,
  output logic [AW-1:0]             push_home_o
);
  import lphs_pkg::*;

  localparam int unsigned NSTEP = (KW + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int unsigned KP    = NSTEP * DIGIT_BITS;
  localparam int unsigned SCW   = (NSTEP > 1) ? $clog2(NSTEP) : 1;
  localparam logic [SCW-1:0] LAST_STEP = SCW'(NSTEP - 1);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } front_st_e;

  front_st_e        state_q, state_d;
  logic [ACT_W-1:0] act_q, act_d;
  logic [KW-1:0]    key_q, key_d;
  logic [KP-1:0]    sh_q, sh_d;
  logic [CFG_W-1:0] rem_q, rem_d;
  logic [SCW-1:0]   step_q, step_d;
  logic [CFG_W-1:0] rem_next;

  always_comb begin
    logic [CFG_W:0] t;
    logic [CFG_W-1:0] r;
    r = rem_q;
    for (int j = 0; j < DIGIT_BITS; j++) begin
      t = {r, sh_q[KP-1-j]};
      if (t >= {1'b0, m_i}) begin
        t = t - {1'b0, m_i};
      end
      r = t[CFG_W-1:0];
    end
    rem_next = r;
  end

  assign s_ready_o     = (state_q == F_IDLE) && en_i;
  assign push_valid_o  = (state_q == F_PUSH);
  assign push_action_o = act_q;
  assign push_key_o    = key_q;
  assign push_home_o   = AW'(rem_q);

  always_comb begin
    state_d = state_q;
    act_d   = act_q;
    key_d   = key_q;
    sh_d    = sh_q;
    rem_d   = rem_q;
    step_d  = step_q;
    unique case (state_q)
      F_IDLE: begin
        if (s_valid_i && en_i) begin
          act_d   = action_i;
          key_d   = key_i;
          sh_d    = KP'(key_i);
          rem_d   = '0;
          step_d  = '0;
          state_d = F_DIV;
        end
      end
      F_DIV: begin
        rem_d  = rem_next;
        sh_d   = sh_q << DIGIT_BITS;
        step_d = step_q + SCW'(1);
        if (step_q == LAST_STEP) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (push_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d;
    key_q <= key_d;
    sh_q  <= sh_d;
    rem_q <= rem_d;
  end

endmodule

// ----- design/lphs_back.sv -----
// ---------------------------------------------------------------------------
// lphs_back
// Probe engine: owns the slot memory, clears it after reset and walks the
// probe sequence one slot per cycle.
// ---------------------------------------------------------------------------
module lphs_back #(
  parameter int unsigned KW    = 32,
  parameter int unsigned AW    = 10,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [lphs_pkg::CFG_W-1:0]  m_i,
  input  logic                        pop_valid_i,
  output logic                        pop_ready_o,
  input  logic [lphs_pkg::ACT_W-1:0]  act_i,
  input  logic [KW-1:0]               key_i,
  input  logic [AW-1:0]               home_i,
  output logic                        clearing_o,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output logic                        res_success_o,
  output logic [lphs_pkg::SLOT_W-1:0] res_slot_o
);
  import lphs_pkg::*;

  localparam int unsigned WW = KW + 2;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  typedef enum logic [2:0] {
    B_CLEAR = 3'b001,
    B_IDLE  = 3'b010,
    B_PROBE = 3'b100
  } back_st_e;

  logic [WW-1:0] mem [DEPTH];
  logic [WW-1:0] rdata_q;

  back_st_e         state_q, state_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [AW-1:0]    p_q, p_d;
  logic [CFG_W-1:0] cnt_q, cnt_d;
  logic [ACT_W-1:0] act_q, act_d;
  logic [KW-1:0]    key_q, key_d;
  logic             have_q, have_d;
  logic [AW-1:0]    free_q, free_d;
  logic             out_valid_q, out_valid_d;
  logic             out_succ_q, out_succ_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;

  logic          re, we;
  logic [AW-1:0] ra, wa;
  logic [WW-1:0] wd;
  logic [1:0]    st;
  logic          hold, is_empty, is_last, have_n, out_free;
  logic [AW-1:0] free_n, nxt;

  assign st       = rdata_q[KW+1:KW];
  assign hold     = (st == ST_ACTIVE) && (rdata_q[KW-1:0] == key_q);
  assign is_empty = (st == ST_EMPTY);
  assign is_last  = (cnt_q == (m_i - CFG_W'(1)));
  assign have_n   = have_q || (st != ST_ACTIVE);
  assign free_n   = have_q ? free_q : p_q;
  assign nxt      = ((32'(p_q) + 32'd1) >= 32'(m_i)) ? '0 : (p_q + AW'(1));
  assign out_free = !out_valid_q || res_ready_i;

  assign pop_ready_o   = (state_q == B_IDLE);
  assign clearing_o    = (state_q == B_CLEAR);
  assign res_valid_o   = out_valid_q;
  assign res_success_o = out_succ_q;
  assign res_slot_o    = out_slot_q;

  always_comb begin
    logic          done, succ;
    logic [AW-1:0] slot;
    state_d     = state_q;
    clr_d       = clr_q;
    p_d         = p_q;
    cnt_d       = cnt_q;
    act_d       = act_q;
    key_d       = key_q;
    have_d      = have_q;
    free_d      = free_q;
    out_valid_d = out_valid_q && !res_ready_i;
    out_succ_d  = out_succ_q;
    out_slot_d  = out_slot_q;
    re          = 1'b0;
    ra          = nxt;
    we          = 1'b0;
    wa          = p_q;
    wd          = {ST_ACTIVE, key_q};
    done        = 1'b1;
    succ        = 1'b0;
    slot        = '0;
    unique case (state_q)
      B_CLEAR: begin
        we    = 1'b1;
        wa    = clr_q;
        wd    = {ST_EMPTY, {KW{1'b0}}};
        clr_d = clr_q + AW'(1);
        if (clr_q == LAST_ADDR) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (pop_valid_i) begin
          act_d   = act_i;
          key_d   = key_i;
          p_d     = home_i;
          cnt_d   = '0;
          have_d  = 1'b0;
          re      = 1'b1;
          ra      = home_i;
          state_d = B_PROBE;
        end
      end
      B_PROBE: begin
        unique case (act_q)
          ACT_INSERT: begin
            done = hold || is_empty || is_last;
            succ = !hold && have_n;
            slot = hold ? p_q : (have_n ? free_n : '0);
          end
          ACT_DELETE: begin
            done = hold || is_last;
            succ = hold;
            slot = hold ? p_q : '0;
          end
          ACT_SEARCH: begin
            done = hold || is_empty || is_last;
            succ = hold;
            slot = hold ? p_q : '0;
          end
          default: begin
            done = 1'b1;
            succ = 1'b0;
            slot = '0;
          end
        endcase
        if (done) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_succ_d  = succ;
            out_slot_d  = SLOT_W'(slot);
            state_d     = B_IDLE;
            if (act_q == ACT_INSERT) begin
              we = succ;
              wa = free_n;
              wd = {ST_ACTIVE, key_q};
            end else if (act_q == ACT_DELETE) begin
              we = hold;
              wa = p_q;
              wd = {ST_DELETED, key_q};
            end
          end
        end else begin
          re     = 1'b1;
          ra     = nxt;
          p_d    = nxt;
          cnt_d  = cnt_q + CFG_W'(1);
          have_d = have_n;
          free_d = free_n;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q        <= p_d;
    cnt_q      <= cnt_d;
    act_q      <= act_d;
    key_q      <= key_d;
    have_q     <= have_d;
    free_q     <= free_d;
    out_succ_q <= out_succ_d;
    out_slot_q <= out_slot_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdata_q <= mem[ra];
    end
  end

endmodule

// ----- design/linear_probe_hash_set.sv -----
// ---------------------------------------------------------------------------
// linear_probe_hash_set
// Open-addressed key set with linear probing: insert, delete and search.
// ---------------------------------------------------------------------------
// Requests arrive on the s_axis channel: tdata holds the action (0 insert,
// 1 delete, 2 search) in bits [1:0] and the key in bits [33:2]. Each request
// gives one result on m_axis: tdata bit 0 is success, bits [10:1] the slot.
// The cfg channel writes table_size (reset 1024); write it only while idle.
// After reset the slot memory is cleared one slot per cycle; s_axis_tready
// stays low until that pass is done. The front computes the home slot with a
// radix-16 remainder unit and hands it over to a two-entry queue. The probe
// engine reads one slot per cycle from the slot memory. Front and probe
// engine overlap: the front can accept a new request while the probe engine
// still works on an earlier one. The result waits in an output register while
// m_axis_tready is low; the probe engine then stalls at its next finished
// operation, and the queue and front keep taking requests until the queue
// is full.
// ---------------------------------------------------------------------------
module linear_probe_hash_set #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned KEY_BITS    = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // action [1:0], key [33:2], zero [39:34]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // success [0], slot [10:1], zero [15:11]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [lphs_pkg::CFG_W-1:0] cfg_data_i
);
  import lphs_pkg::*;

  localparam int unsigned KW = (KEY_BITS < IN_KEY_W) ? KEY_BITS : IN_KEY_W;
  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned QW = ACT_W + KW + AW;

  logic [CFG_W-1:0] table_size_q;
  logic [CFG_W-1:0] m_eff;
  logic             clearing;
  logic [ACT_W-1:0] f_act;
  logic [KW-1:0]    f_key;
  logic [AW-1:0]    f_home;
  logic             f_valid, f_ready;
  logic [QW-1:0]    q_data;
  logic             q_valid, q_ready;
  logic             res_success;
  logic [SLOT_W-1:0] res_slot;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= CFG_W'(1024);
    end else if (cfg_valid_i) begin
      table_size_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (table_size_q == '0) begin
      m_eff = CFG_W'(1);
    end else if (32'(table_size_q) > 32'(TABLE_DEPTH)) begin
      m_eff = CFG_W'(TABLE_DEPTH);
    end else begin
      m_eff = table_size_q;
    end
  end

  lphs_front #(
    .KW(KW),
    .AW(AW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (!clearing),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .action_i     (s_axis_tdata[1:0]),
    .key_i        (KW'(s_axis_tdata[33:2])),
    .m_i          (m_eff),
    .push_valid_o (f_valid),
    .push_ready_i (f_ready),
    .push_action_o(f_act),
    .push_key_o   (f_key),
    .push_home_o  (f_home)
  );

  lphs_fifo #(
    .W(QW)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(f_valid),
    .wr_ready_o(f_ready),
    .wr_data_i ({f_home, f_key, f_act}),
    .rd_valid_o(q_valid),
    .rd_ready_i(q_ready),
    .rd_data_o (q_data)
  );

  lphs_back #(
    .KW   (KW),
    .AW   (AW),
    .DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .m_i          (m_eff),
    .pop_valid_i  (q_valid),
    .pop_ready_o  (q_ready),
    .act_i        (q_data[ACT_W-1:0]),
    .key_i        (q_data[ACT_W+KW-1:ACT_W]),
    .home_i       (q_data[QW-1:ACT_W+KW]),
    .clearing_o   (clearing),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_success_o(res_success),
    .res_slot_o   (res_slot)
  );

  assign m_axis_tdata = {5'b0, res_slot, res_success};

`include "linear_probe_hash_set_assert.svh"

  `LPHS_ASSERT_SAME(a_no_accept_while_clearing, clearing, !s_axis_tready, "accept during clear")
  `LPHS_ASSERT_NEXT(a_front_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready,
                    "front took two items back to back")

endmodule

// ----- test/linear_probe_hash_set_checker.sv -----
// ---------------------------------------------------------------------------
// Hash set result checker
// Watches the request, result and table size channels. Keeps its own copy of
// the slot table and compares every result transfer with the prediction.
// ---------------------------------------------------------------------------
module linear_probe_hash_set_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [lphs_pkg::CFG_W-1:0] cfg_data_i,
  output int          fail_count_o,
  output int          outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import lphs_pkg::*;

  localparam int unsigned DEPTH = 1024;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] slot;
  } answer_t;

  logic [31:0]  key_mem [DEPTH];
  slot_st_e     status_mem [DEPTH];
  logic [CFG_W-1:0] size_reg;
  answer_t      answer_q [$];

  function automatic answer_t apply_request(input logic [1:0] act, input logic [31:0] k);
    int unsigned m;
    int unsigned p;
    int unsigned free_at;
    bit          have_free;
    bit          hit;
    answer_t     a;
    m = (size_reg == 0) ? 1 : (size_reg > DEPTH) ? DEPTH : size_reg;
    p = k % m;
    a = '0;
    have_free = 0;
    hit = 0;
    free_at = 0;
    for (int unsigned i = 0; i < m; i++) begin
      if (status_mem[p] == ST_ACTIVE && key_mem[p] == k) begin
        hit = 1;
        break;
      end
      if (act == ACT_INSERT && status_mem[p] != ST_ACTIVE && !have_free) begin
        have_free = 1;
        free_at = p;
      end
      if (act != ACT_DELETE && status_mem[p] == ST_EMPTY) break;
      p = (p + 1 >= m) ? 0 : p + 1;
    end
    case (act)
      ACT_INSERT: begin
        if (hit) begin
          a.slot = p[SLOT_W-1:0];
        end else if (have_free) begin
          key_mem[free_at] = k;
          status_mem[free_at] = ST_ACTIVE;
          a.ok = 1'b1;
          a.slot = free_at[SLOT_W-1:0];
        end
      end
      ACT_DELETE: begin
        if (hit) begin
          status_mem[p] = ST_DELETED;
          a.ok = 1'b1;
          a.slot = p[SLOT_W-1:0];
        end
      end
      ACT_SEARCH: begin
        if (hit) begin
          a.ok = 1'b1;
          a.slot = p[SLOT_W-1:0];
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t want;
    answer_t got;
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) status_mem[i] = ST_EMPTY;
      size_reg = 11'd1024;
      answer_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) size_reg = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready)
        answer_q.push_back(apply_request(s_axis_tdata[1:0], s_axis_tdata[33:2]));
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[0], m_axis_tdata[10:1]};
        if (answer_q.size() == 0) begin
          $display("%0t: result with none expected, actual ok=%0b slot=%0d",
                   $time, got.ok, got.slot);
          fail_count_o++;
        end else begin
          want = answer_q.pop_front();
          if (got.ok !== want.ok || got.slot !== want.slot || m_axis_tdata[15:11] !== '0) begin
            $display("%0t: mismatch, expected ok=%0b slot=%0d, actual ok=%0b slot=%0d tdata=%h",
                     $time, want.ok, want.slot, got.ok, got.slot, m_axis_tdata);
            fail_count_o++;
          end
        end
      end
    end
    outstanding_o = answer_q.size();
  end
endmodule

// ----- test/linear_probe_hash_set_test.sv -----
// ---------------------------------------------------------------------------
// Hash set testbench
// Drives directed and random insert, delete and search requests through
// several table sizes with bursty input and a stalling result side.
// ---------------------------------------------------------------------------
module linear_probe_hash_set_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lphs_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 4000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i = '0;
  int          fail_count;
  int          outstanding;
  int          cycle_count = 0;
  bit          hold_request = 0;
  int          burst_left = 0;
  logic [31:0] key_pool [12];

  linear_probe_hash_set u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  linear_probe_hash_set_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .fail_count_o(fail_count), .outstanding_o(outstanding)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("linear_probe_hash_set_test NOT OK");
      $finish;
    end
  end

  // Result side: alternating calm and stalling stretches, plus one long hold-off.
  always @(posedge clk_i) begin
    static int hold_left = 0;
    static bit hold_done = 0;
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_request && !hold_done) begin
      hold_done = 1;
      hold_left = 400;
      m_axis_tready <= 1'b0;
    end else if ((cycle_count / 300) % 2 == 0) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 2) != 0);
    end
  end

  task automatic send_request(input logic [1:0] act, input logic [31:0] k);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, k, act};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_table_size(input logic [CFG_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(input int unsigned size, input int count);
    logic [1:0]  act;
    logic [31:0] k;
    int          pick;
    for (int i = 0; i < 12; i++)
      key_pool[i] = (i < 6) ? $urandom_range(0, 3) * size + $urandom_range(0, 2) : $urandom;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      act = (pick < 45) ? ACT_INSERT : (pick < 65) ? ACT_DELETE :
            (pick < 96) ? ACT_SEARCH : ACT_UNUSED;
      k = ($urandom_range(0, 3) != 0) ? key_pool[$urandom_range(0, 11)] : $urandom;
      send_request(act, k);
    end
  endtask

  initial begin
    int unsigned sizes [8] = '{1, 0, 5, 2047, 13, 64, 3, 1024};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_request(ACT_INSERT, 32'd0);
    send_request(ACT_INSERT, 32'd0);
    send_request(ACT_INSERT, 32'd1024);
    send_request(ACT_INSERT, 32'hFFFF_FFFF);
    send_request(ACT_INSERT, 32'd1023);
    send_request(ACT_SEARCH, 32'd1024);
    send_request(ACT_DELETE, 32'd0);
    send_request(ACT_SEARCH, 32'd1024);
    send_request(ACT_INSERT, 32'd2048);
    send_request(ACT_SEARCH, 32'd7);
    send_request(ACT_DELETE, 32'd7);
    send_request(ACT_UNUSED, 32'hFFFF_FFFF);
    send_request(ACT_SEARCH, 32'hFFFF_FFFF);
    send_request(ACT_DELETE, 32'hFFFF_FFFF);
    send_request(ACT_SEARCH, 32'hAAAA_5555);

    write_table_size(11'd1);
    send_request(ACT_INSERT, 32'h5555_AAAA);
    send_request(ACT_INSERT, 32'd9);
    send_request(ACT_SEARCH, 32'h5555_AAAA);

    hold_request = 1;
    random_phase(1024, 100);
    foreach (sizes[i]) begin
      write_table_size(sizes[i][CFG_W-1:0]);
      random_phase((sizes[i] == 0) ? 1 : (sizes[i] > 1024) ? 1024 : sizes[i], 105);
    end

    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("linear_probe_hash_set_test OK");
    end else begin
      $display("linear_probe_hash_set_test NOT OK");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+design
design/lphs_pkg.sv
design/lphs_fifo.sv
design/lphs_front.sv
design/lphs_back.sv
design/linear_probe_hash_set.sv
test/linear_probe_hash_set_checker.sv
test/linear_probe_hash_set_test.sv
